>>> src/vdt_pkg.sv
// Shared types and constants for the vertex deduplication table.
`default_nettype none
package vdt_pkg;
  localparam int ATTRS = 12;
  localparam int ATTR_W = 32;
  localparam int VERT_W = ATTRS * ATTR_W;
  localparam int IDX_OUT_W = 10;

  // IEEE single equality on bit patterns.
  function automatic logic ieee_eq(input logic [ATTR_W-1:0] a, input logic [ATTR_W-1:0] b);
    logic [ATTR_W-2:0] ma;
    logic [ATTR_W-2:0] mb;
    logic nan;
    ma = a[ATTR_W-2:0];
    mb = b[ATTR_W-2:0];
    nan = (ma > 31'h7F800000) || (mb > 31'h7F800000);
    ieee_eq = !nan && (((ma == '0) && (mb == '0)) || (a == b));
  endfunction

  // True when all twelve attributes compare equal.
  function automatic logic vertex_eq(input logic [VERT_W-1:0] s, input logic [VERT_W-1:0] v);
    logic r;
    r = 1'b1;
    for (int k = 0; k < ATTRS; k++) begin
      r = r & ieee_eq(s[k*ATTR_W +: ATTR_W], v[k*ATTR_W +: ATTR_W]);
    end
    vertex_eq = r;
  endfunction
endpackage
`default_nettype wire

>>> src/vdt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none
module vdt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [AW-1:0]            waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [AW-1:0]            raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> src/vertex_dedup_table.sv
// Top level of the vertex deduplication table.
// Each vertex transfer starts a linear search of the stored vertices, one stored vertex read
// from the attribute memory per cycle with the compare in the cycle after its read; with
// sharing off no search is made. The first exact IEEE match returns its index; otherwise
// the vertex is appended, or table_full is flagged when the table holds CAPACITY vertices.
// The result waits in an output register and holds off the next input transfer until it
// is taken. No clearing pass.
`default_nettype none
module vertex_dedup_table
  import vdt_pkg::*;
#(
  parameter int CAPACITY = 1024
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_we,
  input  wire logic         cfg_wdata,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_u, tex_v, col_r, col_g, col_b, col_a
  input  wire logic [383:0] s_tdata,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // vertex_index, was_new, table_full, then zero fill
  output logic [15:0]       m_tdata
);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP = CW'(CAPACITY);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]        state;
  logic              sharing_off;
  logic [CW-1:0]     count;
  logic [CW-1:0]     rd_ptr;
  logic              rd_pend;
  logic [CW-1:0]     cmp_idx;
  logic [VERT_W-1:0] vtx;
  logic [VERT_W-1:0] rdata;
  logic              we;
  logic [AW-1:0]     raddr;
  logic              res_valid;
  logic [IDX_OUT_W-1:0] res_idx;
  logic              res_new;
  logic              res_full;

  assign raddr = rd_ptr[AW-1:0];

  vdt_ram #(.WIDTH(VERT_W), .DEPTH(CAPACITY)) u_ram (
    .clk(clk), .we(we), .waddr(count[AW-1:0]), .wdata(vtx), .raddr(raddr), .rdata(rdata)
  );

  assign s_tready = (state == S_IDLE) && !res_valid;
  assign we = (state == S_DONE) && (count < CAP);
  assign m_tvalid = res_valid;
  assign m_tdata = {4'b0000, res_full, res_new, res_idx};

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      sharing_off <= 1'b0;
    end else if (cfg_we) begin
      sharing_off <= cfg_wdata;
    end
  end

  // Search sequencer: issue reads, compare the registered data in the following cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      res_valid <= 1'b0;
      rd_pend <= 1'b0;
    end else begin
      if (res_valid && m_tready) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid && s_tready) begin
            vtx <= s_tdata;
            rd_ptr <= '0;
            rd_pend <= 1'b0;
            state <= sharing_off ? S_DONE : S_SCAN;
          end
        end
        S_SCAN: begin
          if (rd_pend && vertex_eq(rdata, vtx)) begin
            res_idx <= IDX_OUT_W'(cmp_idx);
            res_new <= 1'b0;
            res_full <= 1'b0;
            res_valid <= 1'b1;
            rd_pend <= 1'b0;
            state <= S_IDLE;
          end else if (rd_ptr < count) begin
            cmp_idx <= rd_ptr;
            rd_ptr <= rd_ptr + 1'b1;
            rd_pend <= 1'b1;
          end else begin
            rd_pend <= 1'b0;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          res_valid <= 1'b1;
          if (count < CAP) begin
            res_idx <= IDX_OUT_W'(count);
            res_new <= 1'b1;
            res_full <= 1'b0;
            count <= count + 1'b1;
          end else begin
            res_idx <= '0;
            res_new <= 1'b0;
            res_full <= 1'b1;
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> bench/vertex_dedup_table_tb.sv
// Self-checking testbench for the vertex deduplication table.
`timescale 1ns / 1ps
`default_nettype none
module vertex_dedup_table_tb
  import vdt_pkg::*;
();

  localparam int CAP = 1024;

  typedef struct packed {
    logic       table_full;
    logic       was_new;
    logic [9:0] vertex_index;
  } lookup_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_wdata;
  logic s_tvalid;
  logic s_tready;
  logic [383:0] s_tdata;
  logic m_tvalid;
  logic m_tready;
  logic [15:0] m_tdata;

  // Shadow copy of the table contents and its setting.
  logic [ATTR_W-1:0] shadow_store[CAP][ATTRS];
  int unsigned shadow_count;
  logic shadow_sharing_off;
  lookup_t pending_lookups[$];
  int errors;
  int rx_gap_max;
  int rx_hold;
  bit hold_toggle;
  bit hold_seen;

  // Pool of previously sent vertices, for repeats.
  logic [VERT_W-1:0] sent_pool[$];

  vertex_dedup_table #(.CAPACITY(CAP)) dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #600ms;
    $display("Simulation FAILED");
    $finish;
  end

  // IEEE single equality on raw bit patterns.
  function automatic bit attr_equal(logic [31:0] a, logic [31:0] b);
    logic [30:0] ma;
    logic [30:0] mb;
    ma = a[30:0];
    mb = b[30:0];
    if (ma > 31'h7F800000 || mb > 31'h7F800000) return 1'b0;
    if (ma == '0 && mb == '0) return 1'b1;
    return a == b;
  endfunction

  // Searches the shadow table unless sharing is off, and appends on a miss unless it is full.
  function automatic lookup_t dedup_lookup(logic [VERT_W-1:0] v);
    lookup_t r;
    bit hit;
    r = '0;
    if (!shadow_sharing_off) begin
      for (int i = 0; i < shadow_count; i++) begin
        hit = 1'b1;
        for (int k = 0; k < ATTRS; k++)
          if (!attr_equal(shadow_store[i][k], v[k*ATTR_W +: ATTR_W])) hit = 1'b0;
        if (hit) begin
          r.vertex_index = i[9:0];
          return r;
        end
      end
    end
    if (shadow_count >= CAP) begin
      r.table_full = 1'b1;
      return r;
    end
    for (int k = 0; k < ATTRS; k++) shadow_store[shadow_count][k] = v[k*ATTR_W +: ATTR_W];
    r.vertex_index = shadow_count[9:0];
    r.was_new = 1'b1;
    shadow_count++;
    return r;
  endfunction

  // Sends one vertex and records the expected lookup result.
  // The valid stays high across back-to-back transfers and drops only for a gap.
  task automatic send_vertex(logic [VERT_W-1:0] v, int gap_max);
    int gap;
    lookup_t exp_lookup;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(0, gap_max * 8) :
          $urandom_range(0, gap_max);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= v;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    exp_lookup = dedup_lookup(v);
    pending_lookups = {pending_lookups, exp_lookup};
    sent_pool = {sent_pool, v};
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk);
    repeat (CAP + 10) @(posedge clk);
  endtask

  task automatic write_sharing_off(logic val);
    cfg_we <= 1'b1;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_sharing_off = val;
  endtask

  function automatic logic [31:0] rand_attr();
    case ($urandom_range(0, 7))
      0: return 32'h00000000;
      1: return 32'h80000000;
      2: return {1'($urandom_range(0, 1)), 8'hFF, 23'($urandom_range(1, 32'h7FFFFF))};
      3: return $urandom_range(0, 3) * 32'h3F800000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [VERT_W-1:0] rand_vertex();
    logic [VERT_W-1:0] v;
    for (int k = 0; k < ATTRS; k++) v[k*ATTR_W +: ATTR_W] = rand_attr();
    return v;
  endfunction

  // Repeat of an earlier vertex, with zeros sign-flipped at random.
  function automatic logic [VERT_W-1:0] repeat_vertex();
    logic [VERT_W-1:0] v;
    v = sent_pool[$urandom_range(0, sent_pool.size() - 1)];
    for (int k = 0; k < ATTRS; k++)
      if (v[k*ATTR_W +: 31] == '0 && $urandom_range(0, 1)) v[k*ATTR_W + 31] ^= 1'b1;
    return v;
  endfunction

  // Extremes, signed zeros, NaN and infinity handling.
  task automatic test_directed();
    logic [VERT_W-1:0] v;
    send_vertex('0, 2);
    send_vertex('1, 2);
    send_vertex({ATTRS{32'h80000000}}, 2);
    send_vertex('0, 2);
    send_vertex({ATTRS{32'h7F800000}}, 2);
    send_vertex({ATTRS{32'h7F800000}}, 2);
    send_vertex({ATTRS{32'hFF800000}}, 2);
    send_vertex({ATTRS{32'h7FC00000}}, 2);
    send_vertex({ATTRS{32'h7FC00000}}, 2);
    send_vertex({ATTRS{32'h7F800001}}, 2);
    v = '0;
    v[11*ATTR_W +: ATTR_W] = 32'hFFFFFFFF;
    send_vertex(v, 2);
    send_vertex({ATTRS{32'h55555555}}, 2);
    send_vertex({ATTRS{32'hAAAAAAAA}}, 2);
    send_vertex({ATTRS{32'h55555555}}, 2);
    drain();
  endtask

  // Sharing off appends duplicates.
  task automatic test_sharing_off();
    write_sharing_off(1'b1);
    send_vertex('0, 2);
    send_vertex('0, 2);
    send_vertex({ATTRS{32'h55555555}}, 2);
    drain();
    write_sharing_off(1'b0);
    send_vertex('0, 2);
    drain();
  endtask

  // Mixed new vertices and repeats under random gaps.
  task automatic test_random(int n, int gap_max);
    for (int i = 0; i < n; i++)
      send_vertex(($urandom_range(0, 2) == 0) ? rand_vertex() : repeat_vertex(), gap_max);
    drain();
  endtask

  // Receiver holds off while the sender keeps offering.
  task automatic test_backpressure();
    hold_toggle = ~hold_toggle;
    test_random(20, 0);
  endtask

  // Output side: random stall with an optional long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_hold <= 0;
      hold_seen <= hold_toggle;
    end else if (hold_toggle != hold_seen) begin
      hold_seen <= hold_toggle;
      m_tready <= 1'b0;
      rx_hold <= 200;
    end else if (rx_hold > 0) begin
      m_tready <= 1'b0;
      rx_hold <= rx_hold - 1;
    end else if (rx_gap_max == 0) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(0, 19) == 0) ? 1'b0 : ($urandom_range(0, rx_gap_max) == 0);
    end
  end

  // Result checker.
  always @(posedge clk) begin
    lookup_t got;
    lookup_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[11:0];
      if (pending_lookups.size() == 0) begin
        $error("unexpected result transfer %h", m_tdata);
        errors++;
      end else begin
        want = pending_lookups.pop_front();
        if (got.vertex_index !== want.vertex_index) begin
          $error("vertex_index expected %0d actual %0d", want.vertex_index, got.vertex_index);
          errors++;
        end
        if (got.was_new !== want.was_new) begin
          $error("was_new expected %0d actual %0d", want.was_new, got.was_new);
          errors++;
        end
        if (got.table_full !== want.table_full) begin
          $error("table_full expected %0d actual %0d", want.table_full, got.table_full);
          errors++;
        end
      end
    end
  end

  initial begin
    errors = 0;
    shadow_count = 0;
    shadow_sharing_off = 1'b0;
    rx_gap_max = 2;
    hold_toggle = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_sharing_off();
    test_backpressure();
    test_random(330, 3);
    rx_gap_max = 0;
    test_random(160, 0);
    rx_gap_max = 2;
    test_random(50, 2);
    if (errors == 0 && pending_lookups.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
